// File: rtl/hashed_timing_wheel_unit_defines.svh
// ----------------------------------------------------------------------------
// Hashed timing wheel assertion macros
// Shared property forms for the checkers of the timing wheel unit.
// ----------------------------------------------------------------------------
`ifndef HASHED_TIMING_WHEEL_UNIT_DEFINES_SVH
`define HASHED_TIMING_WHEEL_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HTW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hashed timing wheel check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hashed timing wheel check failed");

`endif

// File: rtl/htw_pkg.sv
// ----------------------------------------------------------------------------
// Hashed timing wheel package
// Field widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int MAX_TIMERS_DEF  = 64;
  localparam int WHEEL_SLOTS_DEF = 64;

  localparam int HANDLE_W = 6;
  localparam int DELAY_W  = 16;
  localparam int ROUNDS_W = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_REMOVE = 2'd3
  } htw_op_t;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ARMED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ARMED     = 2'd2;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                arm;
    logic                disarm;
    logic [HANDLE_W-1:0] handle;
    logic                shift;
    logic                step;
  } htw_ctl_t;

endpackage

// File: rtl/htw_cell.sv
// ----------------------------------------------------------------------------
// Timing wheel cell
// Holds one timer entry and passes the walk token to the next cell.
// ----------------------------------------------------------------------------
module htw_cell
  import htw_pkg::*;
#(
  parameter int CELL_ID = 0,
  parameter int SLOT_W  = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  htw_ctl_t            ctl,
  input  logic                tok_in,
  input  logic [SLOT_W-1:0]   arm_slot,
  input  logic [ROUNDS_W-1:0] arm_rounds,
  input  logic [SLOT_W-1:0]   cur_slot,
  output logic                tok_out,
  output logic                armed,
  output logic                hit
);

  logic                armed_r, armed_nxt;
  logic                tok_r, tok_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [ROUNDS_W-1:0] rounds_r, rounds_nxt;
  logic                sel;
  logic                match;
  logic                zero;

  assign sel   = (ctl.handle == HANDLE_W'(CELL_ID));
  assign match = armed_r && (slot_r == cur_slot);
  assign zero  = (rounds_r == '0);

  always_comb begin
    armed_nxt  = armed_r;
    tok_nxt    = tok_r;
    slot_nxt   = slot_r;
    rounds_nxt = rounds_r;
    if (ctl.shift) begin
      tok_nxt = tok_in;
    end
    if (ctl.arm && sel) begin
      armed_nxt  = 1'b1;
      slot_nxt   = arm_slot;
      rounds_nxt = arm_rounds;
    end else if (ctl.disarm && sel) begin
      armed_nxt = 1'b0;
    end else if (ctl.step && tok_r && match) begin
      // expire on zero rounds, else count one lap down
      if (zero) begin
        armed_nxt = 1'b0;
      end else begin
        rounds_nxt = rounds_r - ROUNDS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      tok_r   <= tok_nxt;
    end
    slot_r   <= slot_nxt;
    rounds_r <= rounds_nxt;
  end

  assign tok_out = tok_r;
  assign armed   = armed_r;
  assign hit     = tok_r && match && zero;

endmodule

// File: rtl/hashed_timing_wheel_unit.sv
// ----------------------------------------------------------------------------
// Hashed timing wheel unit
// Timer table as a cell chain, walked a cell a cycle per tick unless stalled.
// ----------------------------------------------------------------------------
// Input beats carry the operation in in_tuser and handle and delay in
// in_tdata. Every beat yields one or more result beats on the out_ channel;
// out_tlast marks the final beat caused by an input beat.
// Remove, rejected add and rejected update: the result is registered in the
// accept cycle and shows in the next cycle. Accepted add and update run a
// reciprocal divide of the delay by the wheel size in states S_MUL and S_DIV;
// S_ARM then arms the cell and registers the result. Tick: a token walks the
// cell chain one cell a cycle while the output register is free, through all
// MAX_TIMERS cells, then S_FIN sends the closing beat. Expired handles leave
// in ascending order, each held one step behind so the final one can carry
// out_tlast; a tick without expiry gives one beat with out_tuser low.
// One item is worked at a time. in_tready rises once the unit is idle and
// the output register is free or being emptied.
// When the receiver stalls, the output register holds and the walk freezes
// in place. Reset disarms all timers and sets the current slot to zero.
// ----------------------------------------------------------------------------
module hashed_timing_wheel_unit
  import htw_pkg::*;
#(
  parameter int MAX_TIMERS  = MAX_TIMERS_DEF,
  parameter int WHEEL_SLOTS = WHEEL_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // handle[5:0], delay_seconds[21:6], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // status[1:0], expired_handle[7:2]
  output logic [0:0]  out_tuser,  // expired_valid[0]
  output logic        out_tlast
);

  localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int SH     = DELAY_W + $clog2(WHEEL_SLOTS);
  localparam int PROD_W = SH + DELAY_W;
  localparam logic [DELAY_W:0]   RECIP   = (DELAY_W + 1)'((64'd1 << SH) / WHEEL_SLOTS);
  localparam logic [SLOT_W:0]    W_C     = (SLOT_W + 1)'(WHEEL_SLOTS);
  localparam logic [IDX_W-1:0]   LAST_IX = IDX_W'(MAX_TIMERS - 1);
  localparam logic [HANDLE_W:0]  TBL_LIM = (HANDLE_W + 1)'(MAX_TIMERS);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_ARM, S_WALK, S_FIN
  } state_t;

  state_t                state_r, state_nxt;
  logic [HANDLE_W-1:0]   handle_r, handle_nxt;
  logic [DELAY_W-1:0]    delay_r, delay_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [ROUNDS_W-1:0]   quo_r, quo_nxt;
  logic [SLOT_W:0]       rem_r, rem_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]      pend_handle_r, pend_handle_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic                  out_evalid_r, out_evalid_nxt;
  logic [HANDLE_W-1:0]   out_handle_r, out_handle_nxt;
  logic                  out_last_r, out_last_nxt;

  htw_ctl_t              ctl;
  logic                  out_free;
  logic                  in_fire;
  htw_op_t               op;
  logic [HANDLE_W-1:0]   hnd;
  logic [DELAY_W-1:0]    dly;
  logic                  in_table;
  logic                  armed_sel;
  logic                  any_hit;
  logic [31:0]           qw;
  logic [DELAY_W-1:0]    rem_raw;
  logic [SLOT_W:0]       rem_c;
  logic [ROUNDS_W-1:0]   quo_c;
  logic [SLOT_W:0]       slot_sum;
  logic [SLOT_W-1:0]     arm_slot;

  logic [MAX_TIMERS-1:0] tok_vec;
  logic [MAX_TIMERS-1:0] armed_vec;
  logic [MAX_TIMERS-1:0] hit_vec;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign op        = htw_op_t'(in_tuser);
  assign hnd       = in_tdata[5:0];
  assign dly       = in_tdata[21:6];
  assign in_table  = ({1'b0, hnd} < TBL_LIM);
  assign armed_sel = in_table && armed_vec[hnd[IDX_W-1:0]];
  assign any_hit   = |hit_vec;

  // quotient estimate is at most one low; fix up with one compare/subtract
  assign qw       = 32'(prod_r[SH +: DELAY_W]) * 32'(WHEEL_SLOTS);
  assign rem_raw  = delay_r - qw[DELAY_W-1:0];
  assign rem_c    = (rem_r >= W_C) ? (rem_r - W_C) : rem_r;
  assign quo_c    = (rem_r >= W_C) ? (quo_r + ROUNDS_W'(1)) : quo_r;
  assign slot_sum = {1'b0, cur_r} + rem_c;
  assign arm_slot = (slot_sum >= W_C) ? SLOT_W'(slot_sum - W_C) : slot_sum[SLOT_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    handle_nxt      = handle_r;
    delay_nxt       = delay_r;
    prod_nxt        = prod_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    cur_nxt         = cur_r;
    idx_nxt         = idx_r;
    pend_valid_nxt  = pend_valid_r;
    pend_handle_nxt = pend_handle_r;
    out_valid_nxt   = out_tready ? 1'b0 : out_valid_r;
    out_status_nxt  = out_status_r;
    out_evalid_nxt  = out_evalid_r;
    out_handle_nxt  = out_handle_r;
    out_last_nxt    = out_last_r;
    ctl             = '0;
    ctl.handle      = handle_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          handle_nxt     = hnd;
          delay_nxt      = dly;
          out_status_nxt = STATUS_OK;
          out_evalid_nxt = 1'b0;
          out_handle_nxt = '0;
          out_last_nxt   = 1'b1;
          unique case (op)
            OP_TICK: begin
              ctl.shift      = 1'b1;
              idx_nxt        = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_WALK;
            end
            OP_ADD: begin
              if (in_table && !armed_sel) begin
                state_nxt = S_MUL;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = in_table ? STATUS_ARMED : STATUS_OK;
              end
            end
            OP_UPDATE: begin
              if (armed_sel) begin
                state_nxt = S_MUL;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STATUS_NOT_ARMED;
              end
            end
            OP_REMOVE: begin
              ctl.disarm    = in_table;
              ctl.handle    = hnd;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(delay_r) * PROD_W'(RECIP);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt   = prod_r[SH +: DELAY_W];
        rem_nxt   = rem_raw[SLOT_W:0];
        state_nxt = S_ARM;
      end
      S_ARM: begin
        ctl.arm        = 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = STATUS_OK;
        out_evalid_nxt = 1'b0;
        out_handle_nxt = '0;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_WALK: begin
        if (out_free) begin
          ctl.step  = 1'b1;
          ctl.shift = 1'b1;
          if (any_hit) begin
            // release the held expiry, hold this one back
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_OK;
              out_evalid_nxt = 1'b1;
              out_handle_nxt = HANDLE_W'(pend_handle_r);
              out_last_nxt   = 1'b0;
            end
            pend_valid_nxt  = 1'b1;
            pend_handle_nxt = idx_r;
          end
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == LAST_IX) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_evalid_nxt = pend_valid_r;
          out_handle_nxt = pend_valid_r ? HANDLE_W'(pend_handle_r) : '0;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          cur_nxt        = ({1'b0, cur_r} + (SLOT_W + 1)'(1) == W_C) ? '0
                                                                     : cur_r + SLOT_W'(1);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    handle_r      <= handle_nxt;
    delay_r       <= delay_nxt;
    prod_r        <= prod_nxt;
    quo_r         <= quo_nxt;
    rem_r         <= rem_nxt;
    idx_r         <= idx_nxt;
    pend_handle_r <= pend_handle_nxt;
    out_status_r  <= out_status_nxt;
    out_evalid_r  <= out_evalid_nxt;
    out_handle_r  <= out_handle_nxt;
    out_last_r    <= out_last_nxt;
  end

  for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
    logic tok_in;
    if (g == 0) begin : g_head
      assign tok_in = (state_r == S_IDLE);
    end else begin : g_link
      assign tok_in = tok_vec[g-1];
    end
    htw_cell #(
      .CELL_ID (g),
      .SLOT_W  (SLOT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .tok_in     (tok_in),
      .arm_slot   (arm_slot),
      .arm_rounds (quo_c),
      .cur_slot   (cur_r),
      .tok_out    (tok_vec[g]),
      .armed      (armed_vec[g]),
      .hit        (hit_vec[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_handle_r, out_status_r};
  assign out_tuser  = out_evalid_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/htw_checker.sv
// ----------------------------------------------------------------------------
// Hashed timing wheel checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "hashed_timing_wheel_unit_defines.svh"

module htw_checker
  import htw_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,   // status[1:0], expired_handle[7:2]
  input logic [0:0] out_tuser,   // expired_valid[0]
  input logic       out_tlast
);

  logic [9:0]          out_beat;
  logic [STATUS_W-1:0] out_status;

  assign out_beat   = {out_tlast, out_tuser, out_tdata};
  assign out_status = out_tdata[STATUS_W-1:0];

  `HTW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_beat))
  `HTW_ASSERT_NOW(a_no_expiry_last, out_tvalid && !out_tuser[0], out_tlast)
  `HTW_ASSERT_NOW(a_expiry_status_ok, out_tvalid && out_tuser[0], out_status == STATUS_OK)
  `HTW_ASSERT_NOW(a_status_code, out_tvalid, out_status <= STATUS_ARMED)

endmodule

bind hashed_timing_wheel_unit htw_checker u_htw_checker (.*);

// File: tb/hashed_timing_wheel_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel unit checker
// Watches the input and result streams. It keeps its own copy of the timer
// table and wheel position, predicts the result beats of every accepted input
// beat, and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module hashed_timing_wheel_unit_checker
  import htw_pkg::*;
#(
  parameter int MAX_TIMERS  = MAX_TIMERS_DEF,
  parameter int WHEEL_SLOTS = WHEEL_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // handle[5:0], delay_seconds[21:6], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // status[1:0], expired_handle[7:2]
  input  logic [0:0]  out_tuser,  // expired_valid[0]
  input  logic        out_tlast,
  output int          fail_count,
  output int          beats_pending,
  output int          result_beats,
  output int          expired_beats
);

  localparam int SLOT_W = (WHEEL_SLOTS > 2) ? $clog2(WHEEL_SLOTS) : 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } wheel_beat_t;

  wheel_beat_t         expected_beats[$];
  logic                timer_armed  [MAX_TIMERS];
  logic [SLOT_W-1:0]   timer_slot   [MAX_TIMERS];
  logic [ROUNDS_W-1:0] timer_rounds [MAX_TIMERS];
  logic [SLOT_W-1:0]   wheel_pos;
  int                  fails;
  int                  seen_beats;
  int                  seen_expired;

  function automatic void note_fail(input string msg);
    fails++;
    if (fails <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic void arm_timer(input int h, input logic [DELAY_W-1:0] d);
    timer_slot[h]   = SLOT_W'((int'(wheel_pos) + int'(d) % WHEEL_SLOTS) % WHEEL_SLOTS);
    timer_rounds[h] = ROUNDS_W'(int'(d) / WHEEL_SLOTS);
    timer_armed[h]  = 1'b1;
  endfunction

  // Queue the result beats that one input beat causes, and move the table on.
  task automatic predict_wheel(input htw_op_t op, input logic [HANDLE_W-1:0] h,
                               input logic [DELAY_W-1:0] d);
    int                  fired;
    logic                in_table;
    logic [STATUS_W-1:0] status;
    wheel_beat_t         beat;
    fired    = 0;
    in_table = int'(h) < MAX_TIMERS;
    status   = STATUS_OK;
    if (op == OP_TICK) begin
      for (int i = 0; i < MAX_TIMERS; i++) begin
        if (timer_armed[i] && timer_slot[i] == wheel_pos) begin
          if (timer_rounds[i] == '0) begin
            timer_armed[i] = 1'b0;
            beat = '{STATUS_OK, 1'b1, HANDLE_W'(i), 1'b0};
            expected_beats.push_back(beat);
            fired++;
          end else begin
            timer_rounds[i] = timer_rounds[i] - 1'b1;
          end
        end
      end
      wheel_pos = SLOT_W'((int'(wheel_pos) + 1) % WHEEL_SLOTS);
      if (fired == 0) begin
        beat = '{STATUS_OK, 1'b0, '0, 1'b1};
        expected_beats.push_back(beat);
      end else begin
        // Mark the final expiry of the run.
        beat = expected_beats.pop_back();
        beat.last = 1'b1;
        expected_beats.push_back(beat);
      end
    end else begin
      case (op)
        OP_ADD: begin
          if (in_table) begin
            if (timer_armed[h]) status = STATUS_ARMED;
            else arm_timer(int'(h), d);
          end
        end
        OP_UPDATE: begin
          if (in_table && timer_armed[h]) arm_timer(int'(h), d);
          else status = STATUS_NOT_ARMED;
        end
        default: begin
          if (in_table) timer_armed[h] = 1'b0;
        end
      endcase
      beat = '{status, 1'b0, '0, 1'b1};
      expected_beats.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    wheel_beat_t seen, want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_TIMERS; i++) begin
        timer_armed[i]  = 1'b0;
        timer_slot[i]   = '0;
        timer_rounds[i] = '0;
      end
      wheel_pos = '0;
      expected_beats.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = '{out_tdata[1:0], out_tuser[0], out_tdata[7:2], out_tlast};
        seen_beats++;
        if (seen.valid) seen_expired++;
        if (expected_beats.size() == 0) begin
          note_fail($sformatf("result beat with nothing pending: status %0d valid %0b handle %0d last %0b",
                              seen.status, seen.valid, seen.handle, seen.last));
        end else begin
          want = expected_beats.pop_front();
          if (seen.status !== want.status)
            note_fail($sformatf("status exp %0d got %0d", want.status, seen.status));
          if (seen.valid !== want.valid)
            note_fail($sformatf("expired_valid exp %0b got %0b", want.valid, seen.valid));
          if (seen.handle !== want.handle)
            note_fail($sformatf("expired_handle exp %0d got %0d", want.handle, seen.handle));
          if (seen.last !== want.last)
            note_fail($sformatf("last exp %0b got %0b", want.last, seen.last));
        end
      end
      if (in_tvalid && in_tready)
        predict_wheel(htw_op_t'(in_tuser), in_tdata[5:0], in_tdata[21:6]);
    end
    fail_count    <= fails;
    beats_pending <= expected_beats.size();
    result_beats  <= seen_beats;
    expired_beats <= seen_expired;
  end

endmodule

// File: tb/hashed_timing_wheel_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel unit testbench
// Drives directed and random timer operations and ticks with random source
// gaps and sink stalls; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module hashed_timing_wheel_unit_test;
  import htw_pkg::*;

  localparam int RANDOM_ITEMS = 200;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // handle[5:0], delay_seconds[21:6], zero pad
  logic [1:0]  in_tuser   = '0;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // status[1:0], expired_handle[7:2]
  logic [0:0]  out_tuser;         // expired_valid[0]
  logic        out_tlast;

  int fail_count, beats_pending, result_beats, expired_beats;
  int beats_sent   = 0;
  int ticks_sent   = 0;
  int random_sent  = 0;
  bit steady_src   = 1'b0;
  bit steady_sink  = 1'b0;

  hashed_timing_wheel_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  hashed_timing_wheel_unit_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .beats_pending (beats_pending),
    .result_beats  (result_beats),
    .expired_beats (expired_beats)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return DELAY_W'($urandom_range(0, 70));
    if (r < 85) return DELAY_W'($urandom_range(0, 200));
    return DELAY_W'($urandom());
  endfunction

  task automatic send_beat(input htw_op_t op, input logic [HANDLE_W-1:0] h,
                           input logic [DELAY_W-1:0] d);
    int gap;
    gap = steady_src ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, d, h};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  // Sink: hold each ready level for a random stretch.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (steady_sink) begin
        out_tready <= 1'b1;
        hold = 0;
      end else if (hold == 0) begin
        out_tready <= ($urandom_range(0, 99) < 70);
        hold = pick_gap();
      end else begin
        hold--;
      end
    end
  end

  initial begin
    htw_op_t             op;
    logic [HANDLE_W-1:0] h;
    logic [HANDLE_W-1:0] mask;
    logic [DELAY_W-1:0]  d;
    int                  n, r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty wheel, rejections, extremes, a multi-expiry tick.
    send_beat(OP_TICK,   6'd0,  16'd0);
    send_beat(OP_ADD,    6'd0,  16'd0);
    send_beat(OP_ADD,    6'd0,  16'd5);
    send_beat(OP_UPDATE, 6'd7,  16'd3);
    send_beat(OP_REMOVE, 6'd9,  16'd0);
    send_beat(OP_ADD,    6'd63, 16'hFFFF);
    send_beat(OP_ADD,    6'd1,  16'd64);
    send_beat(OP_ADD,    6'd2,  16'd0);
    send_beat(OP_ADD,    6'd3,  16'd0);
    send_beat(OP_UPDATE, 6'd3,  16'd1);
    send_beat(OP_TICK,   6'd0,  16'd0);
    send_beat(OP_TICK,   6'd0,  16'd0);
    send_beat(OP_REMOVE, 6'd63, 16'd0);
    send_beat(OP_ADD,    6'd63, 16'hAAAA);
    send_beat(OP_UPDATE, 6'd63, 16'h5555);
    send_beat(OP_ADD,    6'd62, 16'd127);
    send_beat(OP_REMOVE, 6'd62, 16'd0);
    send_beat(OP_TICK,   6'd0,  16'd0);
    send_beat(OP_REMOVE, 6'd63, 16'd0);

    while (random_sent < RANDOM_ITEMS) begin
      steady_src  = ($urandom_range(0, 3) == 0);
      steady_sink = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        // Burst: arm many handles on one slot, then tick through it.
        d = DELAY_W'($urandom_range(0, 3));
        if ($urandom_range(0, 5) == 0) begin
          mask = HANDLE_W'($urandom());
          for (int i = 0; i < MAX_TIMERS_DEF; i++) begin
            send_beat(OP_ADD, HANDLE_W'(i) ^ mask, d);
            random_sent++;
          end
        end else begin
          n = $urandom_range(2, 12);
          repeat (n) begin
            send_beat(OP_ADD, HANDLE_W'($urandom()), d);
            random_sent++;
          end
        end
        repeat (int'(d) + 1) begin
          send_beat(OP_TICK, HANDLE_W'($urandom()), DELAY_W'($urandom()));
          random_sent++;
        end
      end else begin
        n = $urandom_range(10, 30);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 35) op = OP_TICK;
          else if (r < 65) op = OP_ADD;
          else if (r < 82) op = OP_UPDATE;
          else op = OP_REMOVE;
          // Reuse a small pool often so operations hit armed handles.
          if ($urandom_range(0, 1) == 0) h = HANDLE_W'($urandom_range(0, 7));
          else h = HANDLE_W'($urandom());
          send_beat(op, h, pick_delay());
          random_sent++;
        end
      end
    end
    in_tvalid   <= 1'b0;
    steady_sink = 1'b0;

    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (MAX_TIMERS_DEF + 20) @(posedge clk);

    $display("run covered %0d input beats, %0d of them ticks", beats_sent, ticks_sent);
    $display("checked %0d result beats, %0d carrying an expired timer",
             result_beats, expired_beats);
    if (fail_count == 0) begin
      $display("hashed_timing_wheel_unit verification clean");
    end else begin
      $display("hashed_timing_wheel_unit verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d result beats outstanding", beats_pending);
    $display("hashed_timing_wheel_unit verification failed");
    $finish;
  end

endmodule
